// ===== rtl/core/fsti_pkg.sv =====
`default_nettype none
package fsti_pkg;
  localparam int unsigned TableDepthDefault = 1024;
  localparam logic        OpCompute = 1'b0;
  localparam logic        OpWrite   = 1'b1;
  localparam logic [31:0] NanPattern = 32'hffc00000;
  localparam logic [7:0]  ExpBias = 8'd127;
  localparam int unsigned IdxW = 10;
  localparam int unsigned WordW = 36;

  typedef struct packed {
    logic        bypass;
    logic [31:0] bypass_bits;
    logic        odd;
    logic        frac_ones;
    logic [22:0] frac;
    logic [7:0]  exp_half;
  } cls_t;

  function automatic logic [7:0] halve_exp(input logic [7:0] e);
    logic [8:0] t;
    if (e >= ExpBias) begin
      t = {1'b0, e - ExpBias};
      return 8'(t[8:1]) + ExpBias;
    end else begin
      t = 9'(ExpBias) - 9'(e) + 9'd1;
      return ExpBias - 8'(t[8:1]);
    end
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/fsti_front.sv =====
`default_nettype none
module fsti_front import fsti_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic        in_op,
  input  wire logic [31:0] in_x,
  output      logic        q_valid,
  input  wire logic        q_ready,
  output      cls_t        q_cls,
  output      logic [8:0]  q_idx_lo
);
  // one-entry skid front; classifies operand and forms table index
  logic full;
  cls_t cls;
  logic [8:0] idx;
  logic [7:0] e;

  assign in_ready = !full || q_ready;
  assign q_valid  = full;

  always_comb begin
    e = in_x[30:23];
    cls.bypass      = (in_x[30:0] == 31'd0) || in_x[31];
    cls.bypass_bits = (in_x[30:0] == 31'd0) ? in_x : NanPattern;
    cls.odd         = e[0];
    cls.frac        = in_x[22:0];
    cls.frac_ones   = &in_x[22:0];
    cls.exp_half    = halve_exp(e);
    idx = e[0] ? {1'b0, in_x[22:15]} : in_x[22:14];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid && (in_op == OpCompute);
    end
    if (in_ready && in_valid) begin
      q_cls    <= cls;
      q_idx_lo <= idx;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/fsti_back.sv =====
`default_nettype none
module fsti_back import fsti_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [IdxW-1:0]  wr_idx,
  input  wire logic [WordW-1:0] wr_word,
  input  wire logic             q_valid,
  output      logic             q_ready,
  input  wire cls_t             q_cls,
  input  wire logic [8:0]       q_idx_lo,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      logic [31:0]      out_bits
);
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned SkidW = 3;

  logic [WordW-1:0] mem [TABLE_DEPTH];
  logic [WordW-1:0] rd_word;
  logic [AW-1:0] rd_addr;
  logic [AW:0]   rd_full;

  // stage 1: memory read; stage 2: multiply; stage 3: subtract into output skid
  logic s1_v, s2_v;
  cls_t s1_c, s2_c;
  logic [23:0] s2_seed;
  logic [28:0] s2_prod;
  logic [13:0] slope1;
  logic [15:0] cof;
  logic [23:0] s3_mant;
  logic [31:0] s3_bits;
  logic [31:0] sk_bits [SkidW];
  logic [31:0] sk_next [SkidW];
  logic [1:0]  cnt;
  logic [1:0]  wp;
  logic        pop;
  logic        adv;
  logic        wr_ok;

  // credit: items in flight plus held must stay within skid
  assign adv     = q_valid && q_ready;
  assign pop     = out_valid && out_ready;
  assign q_ready = (2'(s1_v) + 2'(s2_v) + cnt) < 2'(SkidW) ||
                   ((2'(s1_v) + 2'(s2_v) + cnt) == 2'(SkidW) && out_ready && cnt != 2'd0);
  assign rd_full = (AW+1)'(q_cls.odd ? {1'b0, q_idx_lo[7:0]} : {1'b0, q_idx_lo} + 10'd256);
  assign rd_addr = rd_full[AW-1:0];
  assign wr_ok   = wr_en && ({2'b0, wr_idx} < 12'(TABLE_DEPTH));
  assign wp      = cnt - 2'(pop);

  always_ff @(posedge clk) begin
    if (wr_ok) mem[AW'(wr_idx)] <= wr_word;
    if (adv) rd_word <= mem[rd_addr];
  end

  always_comb begin
    slope1 = {1'b1, rd_word[12:0]};
    cof = s1_c.odd ? (16'h8000 - {1'b0, s1_c.frac[14:0]})
                   : (16'h4000 - {2'b0, s1_c.frac[13:0]});
    s3_mant = s2_seed - (s2_c.odd ? 24'(s2_prod >> 15) : 24'(s2_prod >> 14));
    if (s2_c.bypass) s3_bits = s2_c.bypass_bits;
    else if (!s2_c.odd && s2_c.frac_ones) s3_bits = {1'b0, s2_c.exp_half, s2_c.frac};
    else s3_bits = {1'b0, s2_c.exp_half, s3_mant[22:0]};
  end

  always_comb begin
    sk_next = sk_bits;
    if (pop) begin
      sk_next[0] = sk_bits[1];
      sk_next[1] = sk_bits[2];
    end
    if (s2_v) sk_next[wp] = s3_bits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      s1_v <= adv;
      s2_v <= s1_v;
      cnt  <= cnt + 2'(s2_v) - 2'(pop);
    end
    if (adv) s1_c <= q_cls;
    s2_c    <= s1_c;
    s2_seed <= {1'b1, rd_word[35:13]};
    s2_prod <= 29'(slope1) * 29'(cof);
    sk_bits <= sk_next;
  end

  assign out_valid = cnt != 2'd0;
  assign out_bits  = sk_bits[0];
endmodule
`default_nettype wire

// ===== rtl/core/float_sqrt_table_interp.sv =====
// Approximate single-precision square root from a seed/slope table. Write
// beats (operation=1) load one 36-bit table word and give no result; compute
// beats give one root_bits each, in order. One beat per cycle is accepted
// while in_ready is high; table read, slope multiply and subtract are each
// a pipeline stage, with a three-entry output buffer. Reading an unwritten
// table entry gives an undefined mantissa.
`default_nettype none
module float_sqrt_table_interp import fsti_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic        operation,
  input  wire logic [31:0] operand_bits,
  input  wire logic [9:0]  entry_index,
  input  wire logic [35:0] entry_word,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [31:0] root_bits
);
  logic       q_valid, q_ready;
  cls_t       q_cls;
  logic [8:0] q_idx_lo;

  fsti_front u_front (
    .clk, .rst, .in_valid, .in_ready,
    .in_op(operation), .in_x(operand_bits),
    .q_valid, .q_ready, .q_cls, .q_idx_lo
  );

  fsti_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk, .rst,
    .wr_en(in_valid && in_ready && operation == OpWrite),
    .wr_idx(entry_index), .wr_word(entry_word),
    .q_valid, .q_ready, .q_cls, .q_idx_lo,
    .out_valid, .out_ready, .out_bits(root_bits)
  );

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(root_bits))
    else $error("result changed while stalled");
  a_no_out_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");
  a_neg: assert property (@(posedge clk) disable iff (rst)
    out_valid && root_bits[31] |-> root_bits == NanPattern || root_bits[30:0] == 31'd0)
    else $error("bad sign");
endmodule
`default_nettype wire

// ===== tb/float_sqrt_table_interp_test.sv =====
module float_sqrt_table_interp_test;
  import fsti_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomBeats = 600;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        operation = OpCompute;
  logic [31:0] operand_bits = '0;
  logic [9:0]  entry_index = '0;
  logic [35:0] entry_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] root_bits;

  float_sqrt_table_interp u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .operand_bits(operand_bits),
    .entry_index(entry_index), .entry_word(entry_word),
    .out_valid(out_valid), .out_ready(out_ready), .root_bits(root_bits)
  );

  always #5 clk = ~clk;

  logic [35:0] seed_table [TableDepthDefault];
  bit          entry_loaded [TableDepthDefault];
  logic [31:0] pending_roots [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          sender_busy_mode = 1'b0;
  bit          receiver_busy_mode = 1'b0;

  function automatic logic [9:0] seed_index(input logic [31:0] x);
    if (x[23]) return {2'b00, x[22:15]};
    return 10'd256 + {1'b0, x[22:14]};
  endfunction

  function automatic bit reads_table(input logic [31:0] x);
    return x[30:0] != '0 && !x[31];
  endfunction

  function automatic logic [31:0] predict_root(input logic [31:0] x);
    logic [7:0]  e, eh;
    logic [22:0] frac;
    logic [35:0] w;
    logic [31:0] seed1, slope1, mant;
    if (x[30:0] == '0) return x;
    if (x[31]) return NanPattern;
    e = x[30:23];
    frac = x[22:0];
    w = seed_table[seed_index(x)];
    seed1 = {8'd0, 1'b1, w[35:13]};
    slope1 = {18'd0, 1'b1, w[12:0]};
    if (e[0])
      mant = seed1 - ((slope1 * (32'd32768 - {17'd0, frac[14:0]})) >> 15);
    else if (frac == '1)
      mant = {9'd0, frac};
    else
      mant = seed1 - ((slope1 * (32'd16384 - {18'd0, frac[13:0]})) >> 14);
    if (e >= 8'd127) eh = ((e - 8'd127) >> 1) + 8'd127;
    else eh = 8'd127 - 8'((9'd128 - {1'b0, e}) >> 1);
    return {1'b0, eh, mant[22:0]};
  endfunction

  // one beat; returns after the accepting edge
  task automatic send_beat(input logic op, input logic [31:0] x, input logic [9:0] idx,
                           input logic [35:0] w);
    int unsigned gap;
    bit taken;
    gap = sender_busy_mode ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    operand_bits <= x;
    entry_index <= idx;
    entry_word <= w;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
    if (op == OpWrite) begin
      seed_table[idx] = w;
      entry_loaded[idx] = 1'b1;
    end else begin
      pending_roots.push_back(predict_root(x));
    end
  endtask

  task automatic load_entry(input logic [9:0] idx, input logic [35:0] w);
    send_beat(OpWrite, $urandom, idx, w);
  endtask

  task automatic root_beat(input logic [31:0] x);
    logic [9:0] idx;
    idx = seed_index(x);
    if (reads_table(x) && !entry_loaded[idx])
      load_entry(idx, 36'({$urandom, $urandom}));
    send_beat(OpCompute, x, 10'($urandom), 36'({$urandom, $urandom}));
  endtask

  task automatic drain_roots();
    while (pending_roots.size() != 0) @(posedge clk);
  endtask

  task automatic test_table_extremes();
    load_entry(10'd0, '0);
    load_entry(10'd255, '1);
    load_entry(10'd256, 36'h0_0000_1fff);
    load_entry(10'd767, 36'hf_ffff_e000);
    load_entry(10'd1023, '1);
    load_entry(10'd768, 36'h5_5555_5555);
  endtask

  task automatic test_special_operands();
    root_beat(32'h0000_0000);
    root_beat(32'h8000_0000);
    root_beat(32'h8000_0001);
    root_beat(32'hbf80_0000);
    root_beat(32'hffff_ffff);
    root_beat(32'h7f80_0000);
    root_beat(32'h7fc0_0000);
    root_beat(32'h7fff_ffff);
    root_beat(32'h0000_0001);
    root_beat(32'h007f_ffff);
    root_beat(32'h3f80_0000);
    root_beat(32'h3f7f_ffff);
    root_beat(32'h3f00_0000);
    root_beat(32'h4000_0000);
    root_beat(32'h3fff_ffff);
    root_beat(32'h0080_0000);
    root_beat(32'h7f7f_ffff);
  endtask

  task automatic test_random_mix();
    logic [31:0] x;
    for (int n = 0; n < RandomBeats; n++) begin
      if (n % 100 == 0) begin
        sender_busy_mode = $urandom_range(0, 3) != 0;
        receiver_busy_mode = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 9) == 0) begin
        load_entry(10'($urandom), 36'({$urandom, $urandom}));
      end else begin
        x = $urandom;
        case ($urandom_range(0, 9))
          0: x[31] = 1'b1;
          1: x[22:0] = '1;
          2: x[30:0] = '0;
          3: x[30:23] = '1;
          4: x[30:23] = '0;
          default: x[31] = 1'b0;
        endcase
        root_beat(x);
      end
      if (n == RandomBeats / 2) begin
        in_valid <= 1'b0;
        drain_roots();
        @(posedge clk);
      end
    end
  endtask

  // receiver stall per result
  int unsigned stall_left = 0;
  bit          result_taken = 1'b0;

  always @(negedge clk) begin
    result_taken = 1'b0;
    if (!rst && out_valid && out_ready) begin
      result_taken = 1'b1;
      if (pending_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected root beat: %h", root_bits);
      end else begin
        if (root_bits !== pending_roots[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("root_bits mismatch: expected %h, got %h", pending_roots[0], root_bits);
        end
        void'(pending_roots.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (result_taken || !out_ready) begin
      if (result_taken)
        stall_left = receiver_busy_mode ? $urandom_range(0, 3) : 0;
      if (stall_left == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        stall_left--;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    sender_busy_mode = 1'b1;
    receiver_busy_mode = 1'b1;
    test_table_extremes();
    test_special_operands();
    test_random_mix();
    in_valid <= 1'b0;
    drain_roots();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_roots.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
